// File: rtl/lsms_pkg.sv
// ----------------------------------------------------------------------------
// lsms_pkg: shared types and constants of the LED sweep mood sequencer
// Holds the item structs, the mode, opcode and controller state codes, the
// command and status bundles and the divide-by-100 helper.
// ----------------------------------------------------------------------------
package lsms_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HES_W      = 9;
  localparam int unsigned REST_W     = 16;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned LVL_W      = 7;
  localparam int unsigned LED_W      = 4;
  localparam int unsigned PROD_W     = 14;
  localparam int unsigned QUOT_W     = 8;

  localparam logic [REST_W-1:0] NORMAL_REST_RST = 16'd200;
  localparam logic [REST_W-1:0] SCARED_REST_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_REST = 1'b0,
    REG_SCARED_REST = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_TAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_READY   = 3'd0,
    MODE_SWEEP   = 3'd1,
    MODE_TIRED   = 3'd2,
    MODE_FRIGHT  = 3'd3,
    MODE_EXHAUST = 3'd4,
    MODE_HESIT   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_DIV,
    S_REM,
    S_SPLIT,
    S_LEVEL,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [HES_W-1:0] hesitate_ticks;
  } in_item_t;

  typedef struct packed {
    logic             lit;
    logic [LED_W-1:0] first_led;
    logic [LVL_W-1:0] first_level;
    logic [LED_W-1:0] second_led;
    logic [LVL_W-1:0] second_level;
    logic [2:0]       mode;
  } out_item_t;

  typedef struct packed {
    logic             lit;
    logic [LED_W-1:0] first_led;
    logic [LVL_W-1:0] first_level;
    logic [LED_W-1:0] second_led;
    logic [LVL_W-1:0] second_level;
  } led_req_t;

  typedef struct packed {
    logic latch_in;
    logic step;
    logic mul;
    logic div;
    logic rem;
    logic split;
    logic level;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_calc;
  } ctl_sts_t;

  // Quotient by 100 through a reciprocal, exact for every 14-bit input.
  function automatic logic [QUOT_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

endpackage

// File: rtl/lsms_ctrl.sv
// ----------------------------------------------------------------------------
// lsms_ctrl: sequencing controller
// Accepts one item at a time, steps the datapath through the state update
// and, if need_calc is set, the LED split stages; owns the output valid flag.
// ----------------------------------------------------------------------------
module lsms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsms_pkg::ctl_cmd_t cmd_o,
  input  lsms_pkg::ctl_sts_t sts_i
);

  lsms_pkg::ctl_state_e state_d, state_q;
  logic                 out_valid_d, out_valid_q;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsms_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsms_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lsms_pkg::S_STEP;
      end
      lsms_pkg::S_STEP: begin
        state_d = sts_i.need_calc ? lsms_pkg::S_MUL : lsms_pkg::S_OUT;
      end
      lsms_pkg::S_MUL:   state_d = lsms_pkg::S_DIV;
      lsms_pkg::S_DIV:   state_d = lsms_pkg::S_REM;
      lsms_pkg::S_REM:   state_d = lsms_pkg::S_SPLIT;
      lsms_pkg::S_SPLIT: state_d = lsms_pkg::S_LEVEL;
      lsms_pkg::S_LEVEL: state_d = lsms_pkg::S_OUT;
      lsms_pkg::S_OUT: begin
        if (out_free) state_d = lsms_pkg::S_IDLE;
      end
      default: state_d = lsms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lsms_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      lsms_pkg::S_STEP:  cmd_o.step  = 1'b1;
      lsms_pkg::S_MUL:   cmd_o.mul   = 1'b1;
      lsms_pkg::S_DIV:   cmd_o.div   = 1'b1;
      lsms_pkg::S_REM:   cmd_o.rem   = 1'b1;
      lsms_pkg::S_SPLIT: cmd_o.split = 1'b1;
      lsms_pkg::S_LEVEL: cmd_o.level = 1'b1;
      lsms_pkg::S_OUT:   cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  a_accept_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == lsms_pkg::S_STEP))
    else $error("accepted item did not enter the step state");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread result");

  a_calc_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsms_pkg::S_STEP && sts_i.need_calc) |=> (state_q == lsms_pkg::S_MUL))
    else $error("sweep tick skipped the LED split stages");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

// File: rtl/lsms_dpath.sv
// ----------------------------------------------------------------------------
// lsms_dpath: mood state and LED split datapath
// Holds the rest registers, mode, sweep position, counters and the held LED
// request, and computes the LED pair and levels in registered stages.
// ----------------------------------------------------------------------------
module lsms_dpath #(
  parameter int unsigned NUM_LEDS     = 12,
  parameter int unsigned MAX_HESITATE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsms_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  lsms_pkg::in_item_t                  in_item_i,
  output lsms_pkg::out_item_t                 out_item_o,
  input  lsms_pkg::ctl_cmd_t                  cmd_i,
  output lsms_pkg::ctl_sts_t                  sts_o
);

  localparam logic [lsms_pkg::PROD_W-1:0] LED_SPAN = lsms_pkg::PROD_W'(NUM_LEDS - 1);
  localparam logic [16:0]                 HES_MAX  = 17'(MAX_HESITATE);

  logic [lsms_pkg::REST_W-1:0] normal_rest_d, normal_rest_q;
  logic [lsms_pkg::REST_W-1:0] scared_rest_d, scared_rest_q;
  lsms_pkg::mode_e             mode_d, mode_q;
  logic [lsms_pkg::POS_W-1:0]  pos_d, pos_q;
  lsms_pkg::led_req_t          req_d, req_q;

  logic [1:0]                  op_d, op_q;
  logic [lsms_pkg::HES_W-1:0]  hes_in_d, hes_in_q;
  logic [lsms_pkg::REST_W-1:0] rest_d, rest_q;
  logic [lsms_pkg::HES_W-1:0]  hcnt_d, hcnt_q;
  logic [lsms_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [lsms_pkg::LVL_W-1:0]  bright_d, bright_q;
  logic [lsms_pkg::QUOT_W-1:0] lo_d, lo_q;
  logic [lsms_pkg::LVL_W-1:0]  frac_d, frac_q;
  logic [lsms_pkg::PROD_W-1:0] p1_d, p1_q, p2_d, p2_q;
  lsms_pkg::out_item_t         out_d, out_q;

  logic [lsms_pkg::POS_W-1:0]  pos_inc;
  logic [lsms_pkg::REST_W-1:0] rest_dec;
  logic [lsms_pkg::HES_W-1:0]  hcnt_dec;
  logic [lsms_pkg::HES_W-1:0]  hes_sat;
  logic [lsms_pkg::REST_W-1:0] normal_load, scared_load;
  logic [lsms_pkg::LVL_W-1:0]  inv_pos;
  logic [lsms_pkg::QUOT_W-1:0] hi_led;
  logic                        sweeping;

  assign pos_inc     = pos_q + 7'd1;
  assign rest_dec    = rest_q - 16'd1;
  assign hcnt_dec    = hcnt_q - 9'd1;
  assign normal_load = (normal_rest_q == '0) ? 16'd1 : normal_rest_q;
  assign scared_load = (scared_rest_q == '0) ? 16'd1 : scared_rest_q;
  assign sweeping    = (mode_q == lsms_pkg::MODE_SWEEP) || (mode_q == lsms_pkg::MODE_FRIGHT);
  assign inv_pos     = 7'd100 - pos_q;
  assign hi_led      = (frac_q != '0) ? lo_q + 8'd1 : lo_q;

  assign sts_o.need_calc = (op_q == lsms_pkg::OP_TICK) && sweeping && (pos_inc < 7'd100);

  always_comb begin
    hes_sat = (hes_in_q == '0) ? 9'd1 : hes_in_q;
    if (17'(hes_sat) > HES_MAX) hes_sat = lsms_pkg::HES_W'(MAX_HESITATE);
  end

  always_comb begin
    normal_rest_d = normal_rest_q;
    scared_rest_d = scared_rest_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsms_pkg::REG_NORMAL_REST: normal_rest_d = cfg_wdata_i;
        lsms_pkg::REG_SCARED_REST: scared_rest_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    op_d     = cmd_i.latch_in ? in_item_i.op : op_q;
    hes_in_d = cmd_i.latch_in ? in_item_i.hesitate_ticks : hes_in_q;
  end

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    rest_d = rest_q;
    hcnt_d = hcnt_q;
    req_d  = req_q;
    if (cmd_i.step) begin
      case (op_q)
        lsms_pkg::OP_TICK: begin
          if (sweeping) begin
            pos_d = pos_inc;
            if (pos_inc >= 7'd100) begin
              req_d  = '0;
              mode_d = (mode_q == lsms_pkg::MODE_SWEEP) ? lsms_pkg::MODE_TIRED
                                                        : lsms_pkg::MODE_EXHAUST;
            end
          end else if (mode_q == lsms_pkg::MODE_TIRED || mode_q == lsms_pkg::MODE_EXHAUST) begin
            rest_d = rest_dec;
            if (rest_dec == '0) mode_d = lsms_pkg::MODE_READY;
          end else if (mode_q == lsms_pkg::MODE_HESIT) begin
            hcnt_d = hcnt_dec;
            if (hcnt_dec == '0) begin
              pos_d  = '0;
              req_d  = '0;
              rest_d = scared_load;
              mode_d = lsms_pkg::MODE_FRIGHT;
            end
          end
        end
        lsms_pkg::OP_START: begin
          if (mode_q == lsms_pkg::MODE_READY) begin
            pos_d  = '0;
            req_d  = '0;
            rest_d = normal_load;
            mode_d = lsms_pkg::MODE_SWEEP;
          end
        end
        lsms_pkg::OP_TAP: begin
          if (mode_q == lsms_pkg::MODE_READY || mode_q == lsms_pkg::MODE_TIRED) begin
            hcnt_d = hes_sat;
            mode_d = lsms_pkg::MODE_HESIT;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.level) begin
      req_d.lit          = 1'b1;
      req_d.first_led    = lo_q[lsms_pkg::LED_W-1:0];
      req_d.second_led   = hi_led[lsms_pkg::LED_W-1:0];
      req_d.first_level  = lsms_pkg::LVL_W'(lsms_pkg::div100(p1_q));
      req_d.second_level = lsms_pkg::LVL_W'(lsms_pkg::div100(p2_q));
    end
  end

  always_comb begin
    prod_d   = cmd_i.mul ? LED_SPAN * lsms_pkg::PROD_W'(inv_pos) : prod_q;
    bright_d = bright_q;
    if (cmd_i.mul) begin
      bright_d = (pos_q < 7'd50) ? {pos_q[5:0], 1'b0} : {inv_pos[5:0], 1'b0};
    end
    lo_d   = cmd_i.div ? lsms_pkg::div100(prod_q) : lo_q;
    frac_d = cmd_i.rem ? lsms_pkg::LVL_W'(prod_q - lsms_pkg::PROD_W'(lo_q) * 14'd100)
                       : frac_q;
    p1_d   = cmd_i.split ? lsms_pkg::PROD_W'(bright_q) * lsms_pkg::PROD_W'(7'd100 - frac_q)
                         : p1_q;
    p2_d   = cmd_i.split ? lsms_pkg::PROD_W'(bright_q) * lsms_pkg::PROD_W'(frac_q) : p2_q;
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      out_d.lit          = req_q.lit;
      out_d.first_led    = req_q.first_led;
      out_d.first_level  = req_q.first_level;
      out_d.second_led   = req_q.second_led;
      out_d.second_level = req_q.second_level;
      out_d.mode         = mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_rest_q <= lsms_pkg::NORMAL_REST_RST;
      scared_rest_q <= lsms_pkg::SCARED_REST_RST;
      mode_q        <= lsms_pkg::MODE_READY;
      pos_q         <= '0;
      req_q         <= '0;
    end else begin
      normal_rest_q <= normal_rest_d;
      scared_rest_q <= scared_rest_d;
      mode_q        <= mode_d;
      pos_q         <= pos_d;
      req_q         <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    hes_in_q <= hes_in_d;
    rest_q   <= rest_d;
    hcnt_q   <= hcnt_d;
    prod_q   <= prod_d;
    bright_q <= bright_d;
    lo_q     <= lo_d;
    frac_q   <= frac_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    out_q    <= out_d;
  end

  assign out_item_o = out_q;

endmodule

// File: rtl/led_sweep_mood_sequencer.sv
// ----------------------------------------------------------------------------
// led_sweep_mood_sequencer: LED sweep mood sequencer top level
// Items arrive on a valid/ready input channel (op, hesitate_ticks) and each
// item produces one result item on a valid/ready output channel carrying the
// requested LED pair, their levels and the mode after the item.
// The rest lengths are set through a write port: cfg_we_i, cfg_idx_i (0 for
// the normal rest, 1 for the frightened rest) and cfg_wdata_i, taken at once.
// One item is in work at a time. A start, tap or resting tick passes through
// the step and output states; a tick that moves a sweep also passes through
// the multiply, divide-by-100, remainder, split and level stages of the
// datapath between them. A new item is taken only after the last result is
// loaded into the output register.
// A finished result waits in the output register; the next item is still
// accepted and worked on, and then waits until the output is taken.
// After reset the block is ready with no LED lit, sweep position zero and
// rest lengths of 200 and 1000 ticks.
// ----------------------------------------------------------------------------
module led_sweep_mood_sequencer #(
  parameter int unsigned NUM_LEDS     = 12,
  parameter int unsigned MAX_HESITATE = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lsms_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lsms_pkg::out_item_t             out_item_o
);

  lsms_pkg::ctl_cmd_t cmd;
  lsms_pkg::ctl_sts_t sts;

  lsms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lsms_dpath #(
    .NUM_LEDS    (NUM_LEDS),
    .MAX_HESITATE(MAX_HESITATE)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
